// ----- rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants and initial hash values for the hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBits = 512;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthAt = 6'd56;
  localparam logic [3:0] ChunkBytes = 4'd8;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    SH_NONE  = 3'd0,
    SH_CHUNK = 3'd1,
    SH_PAD   = 3'd2,
    SH_ZERO  = 3'd3,
    SH_LEN   = 3'd4
  } shift_sel_t;

  typedef struct packed {
    logic       load_chunk;
    shift_sel_t shift_sel;
    logic       init_work;
    logic       do_round;
    logic [5:0] rnd;
    logic       do_update;
    logic       restart;
    logic [1:0] out_idx;
  } sha_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
  } sha_stat_t;

  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sha_if.sv -----
// ----------------------------------------------------------------------------
// sha_if
// Valid/ready channels for message chunks and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha_chunk_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_chunk;
  logic [3:0]  valid_bytes;
  logic        end_of_message;
  modport source (output valid, message_chunk, valid_bytes, end_of_message, input ready);
  modport sink (input valid, message_chunk, valid_bytes, end_of_message, output ready);
endinterface

interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_pair;
  logic        digest_last;
  modport source (output valid, digest_pair, digest_last, input ready);
  modport sink (input valid, digest_pair, digest_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/sha_datapath.sv -----
// ----------------------------------------------------------------------------
// sha_datapath
// Block shift buffer, message schedule, round unit and hash state.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sha_pkg::sha_cmd_t cmd,
  output sha_pkg::sha_stat_t    stat,
  input  wire logic [63:0]      message_chunk,
  input  wire logic [3:0]       chunk_count,
  output logic [63:0]           digest_pair
);
  import sha_pkg::*;

  logic [5:0]           fill;
  logic [BlockBits-1:0] blk;
  logic [63:0]          chunk;
  logic [63:0]          bits;
  word_t                hash [8];
  word_t                wk [8];
  logic [7:0]           byte_in;
  word_t                w0, w1, w9, w14, w_new, s0, s1;
  word_t                ch, maj, se, sa, t1, t2;

  assign stat.fill_last   = (fill == 6'd63);
  assign stat.fill_at_len = (fill == LengthAt);

  always_comb begin
    unique case (cmd.shift_sel)
      SH_CHUNK: byte_in = chunk[63:56];
      SH_PAD:   byte_in = PadMark;
      SH_LEN:   byte_in = bits[63:56];
      default:  byte_in = 8'd0;
    endcase
  end

  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  assign ch  = (wk[4] & wk[5]) ^ (~wk[4] & wk[6]);
  assign maj = (wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]);
  assign se  = rotr(wk[4], 6) ^ rotr(wk[4], 11) ^ rotr(wk[4], 25);
  assign sa  = rotr(wk[0], 2) ^ rotr(wk[0], 13) ^ rotr(wk[0], 22);
  assign t1  = wk[7] + se + ch + RoundK[cmd.rnd] + w0;
  assign t2  = sa + maj;

  assign digest_pair = {hash[{cmd.out_idx, 1'b0}], hash[{cmd.out_idx, 1'b1}]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.restart) begin
      fill <= '0;
    end else if (cmd.shift_sel != SH_NONE) begin
      fill <= fill + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      bits <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= HashInit[i];
    end else begin
      if (cmd.load_chunk) bits <= bits + {57'd0, chunk_count, 3'd0};
      else if (cmd.shift_sel == SH_LEN) bits <= {bits[55:0], 8'd0};
      if (cmd.do_update) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wk[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_chunk) chunk <= message_chunk;
    else if (cmd.shift_sel == SH_CHUNK) chunk <= {chunk[55:0], 8'd0};
    if (cmd.shift_sel != SH_NONE) blk <= {blk[BlockBits-9:0], byte_in};
    else if (cmd.do_round) blk <= {blk[BlockBits-33:0], w_new};
    if (cmd.init_work) begin
      for (int i = 0; i < 8; i++) wk[i] <= hash[i];
    end else if (cmd.do_round) begin
      wk[0] <= t1 + t2;
      wk[1] <= wk[0];
      wk[2] <= wk[1];
      wk[3] <= wk[2];
      wk[4] <= wk[3] + t1;
      wk[5] <= wk[4];
      wk[6] <= wk[5];
      wk[7] <= wk[6];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer for byte append, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        valid_bytes,
  input  wire logic              end_of_message,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_last,
  output logic [3:0]             chunk_count,
  output sha_pkg::sha_cmd_t      cmd,
  input  wire sha_pkg::sha_stat_t stat
);
  import sha_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_LOAD   = 8'b00000010,
    S_PAD    = 8'b00000100,
    S_ZERO   = 8'b00001000,
    S_LEN    = 8'b00010000,
    S_ROUND  = 8'b00100000,
    S_UPDATE = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

  state_t     state, state_next, ret, ret_next;
  logic [3:0] rem, rem_next;
  logic [5:0] rnd, rnd_next;
  logic [1:0] idx, idx_next;
  logic       eom, eom_next;

  assign chunk_count = (valid_bytes > ChunkBytes) ? ChunkBytes : valid_bytes;
  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign out_last    = (idx == 2'd3);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    rem_next   = rem;
    rnd_next   = rnd;
    idx_next   = idx;
    eom_next   = eom;
    cmd        = '0;
    cmd.rnd     = rnd;
    cmd.out_idx = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_chunk = 1'b1;
          rem_next       = chunk_count;
          eom_next       = end_of_message;
          state_next     = S_LOAD;
        end
      end
      S_LOAD: begin
        if (rem == 4'd0) begin
          state_next = eom ? S_PAD : S_IDLE;
        end else begin
          cmd.shift_sel = SH_CHUNK;
          rem_next      = rem - 4'd1;
          if (stat.fill_last) begin
            cmd.init_work = 1'b1;
            rnd_next      = '0;
            ret_next      = S_LOAD;
            state_next    = S_ROUND;
          end
        end
      end
      S_PAD: begin
        cmd.shift_sel = SH_PAD;
        state_next    = S_ZERO;
        if (stat.fill_last) begin
          cmd.init_work = 1'b1;
          rnd_next      = '0;
          ret_next      = S_ZERO;
          state_next    = S_ROUND;
        end
      end
      S_ZERO: begin
        if (stat.fill_at_len) begin
          rem_next   = ChunkBytes;
          state_next = S_LEN;
        end else begin
          cmd.shift_sel = SH_ZERO;
          if (stat.fill_last) begin
            cmd.init_work = 1'b1;
            rnd_next      = '0;
            ret_next      = S_ZERO;
            state_next    = S_ROUND;
          end
        end
      end
      S_LEN: begin
        cmd.shift_sel = SH_LEN;
        rem_next      = rem - 4'd1;
        if (stat.fill_last) begin
          cmd.init_work = 1'b1;
          rnd_next      = '0;
          ret_next      = S_OUT;
          state_next    = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        rnd_next     = rnd + 6'd1;
        if (rnd == 6'd63) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.do_update = 1'b1;
        idx_next      = '0;
        state_next    = ret;
      end
      S_OUT: begin
        if (out_ready) begin
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            cmd.restart = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      rem   <= '0;
      rnd   <= '0;
      idx   <= '0;
      eom   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rem   <= rem_next;
      rnd   <= rnd_next;
      idx   <= idx_next;
      eom   <= eom_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_message_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte message fed as chunks of up to eight bytes.
// ----------------------------------------------------------------------------
// channel | dir | payload
// chunk   | in  | message_chunk[63:0], valid_bytes[3:0], end_of_message
// digest  | out | digest_pair[63:0], digest_last
//
// A chunk appends one byte per cycle, pausing for the rounds whenever the block fills.
// Each full block runs 64 rounds on the single round unit, then an update.
// Finish adds padding bytes, one or two blocks, then four digest transfers.
// One chunk is in work at a time; digest stalls hold the block.
// Reset is synchronous; hash state returns to the initial values.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_message_hasher (
  input  wire logic clk,
  input  wire logic rst,
  sha_chunk_if.sink   chunk,
  sha_digest_if.source digest
);
  import sha_pkg::*;

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [3:0] chunk_count;

  sha_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (chunk.valid),
    .in_ready       (chunk.ready),
    .valid_bytes    (chunk.valid_bytes),
    .end_of_message (chunk.end_of_message),
    .out_valid      (digest.valid),
    .out_ready      (digest.ready),
    .out_last       (digest.digest_last),
    .chunk_count    (chunk_count),
    .cmd            (cmd),
    .stat           (stat)
  );

  sha_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .message_chunk (chunk.message_chunk),
    .chunk_count   (chunk_count),
    .digest_pair   (digest.digest_pair)
  );

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(chunk.ready && digest.valid))
    else $error("input taken during digest output");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.digest_last) |=> chunk.ready)
    else $error("no return to idle after digest");
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (chunk.valid && chunk.ready) |=> !chunk.ready)
    else $error("chunk transfer not processed");
`endif
endmodule
`default_nettype wire
